[rtl/gle_pkg.sv]
// Shared types and codes for the GIF LZW encoder.
package gle_pkg;

    localparam int CODE_BITS        = 12;
    localparam int KEY_BITS         = CODE_BITS + 8;
    localparam int DICT_ENTRIES_DEF = 4096;

    localparam logic [CODE_BITS-1:0] CLEAR_CODE = 12'd256;
    localparam logic [CODE_BITS-1:0] END_CODE   = 12'd257;
    localparam logic [CODE_BITS-1:0] FIRST_FREE = 12'd258;
    localparam logic [3:0]           START_WIDTH = 4'd9;
    localparam logic [3:0]           WIDTH_CAP   = 4'd12;
    localparam logic [3:0]           MAX_BITS_RESET = 4'd12;

    // Selector for the code handed to the bit packer
    localparam logic [1:0] PUT_CLEAR  = 2'd0;
    localparam logic [1:0] PUT_END    = 2'd1;
    localparam logic [1:0] PUT_PREFIX = 2'd2;

    typedef struct packed {
        logic [7:0] pixel_index;
        logic       end_of_image;
    } pixel_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       final_byte;
    } byte_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       take_ok;
        logic       put;
        logic [1:0] put_sel;
        logic       mark_start;
        logic       set_px;
        logic       set_pv;
        logic       probe_start;
        logic       probe_next;
        logic       take_code;
        logic       insert;
        logic       table_reset;
        logic       hold_last;
        logic       flush;
        logic       image_reset;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic accepted;
        logic init_busy;
        logic started;
        logic prefix_valid;
        logic eoi;
        logic pk_ready;
        logic flush_ok;
        logic slot_live;
        logic dict_ok;
        logic key_eq;
        logic need_clear;
    } stat_t;

endpackage

[rtl/gle_ctrl.sv]
// Sequencer for one pixel: clear code, dictionary probe, insert, end of image.
module gle_ctrl
    import gle_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t st,
    output cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_PROBE = 4'd3;
    localparam logic [3:0] S_SLOT  = 4'd4;
    localparam logic [3:0] S_DICT  = 4'd5;
    localparam logic [3:0] S_MISS  = 4'd6;
    localparam logic [3:0] S_INS   = 4'd7;
    localparam logic [3:0] S_FULL  = 4'd8;
    localparam logic [3:0] S_CLR   = 4'd9;
    localparam logic [3:0] S_EOI   = 4'd10;
    localparam logic [3:0] S_END1  = 4'd11;
    localparam logic [3:0] S_END2  = 4'd12;
    localparam logic [3:0] S_FLUSH = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take_ok = !st.init_busy;
                if (st.accepted)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (st.started)
                begin
                    state_next = S_CHK;
                end
                else if (st.pk_ready)
                begin
                    cmd.put        = 1'b1;
                    cmd.put_sel    = PUT_CLEAR;
                    cmd.mark_start = 1'b1;
                    state_next     = S_CHK;
                end
            end
            S_CHK:
            begin
                if (!st.prefix_valid)
                begin
                    cmd.set_px = 1'b1;
                    cmd.set_pv = 1'b1;
                    state_next = S_EOI;
                end
                else
                begin
                    cmd.probe_start = 1'b1;
                    state_next      = S_PROBE;
                end
            end
            S_PROBE:
            begin
                state_next = S_SLOT;
            end
            S_SLOT:
            begin
                state_next = st.slot_live ? S_DICT : S_MISS;
            end
            S_DICT:
            begin
                if (st.dict_ok && st.key_eq)
                begin
                    cmd.take_code = 1'b1;
                    state_next    = S_EOI;
                end
                else if (st.dict_ok)
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = S_PROBE;
                end
                else
                begin
                    state_next = S_MISS;
                end
            end
            S_MISS:
            begin
                if (st.pk_ready)
                begin
                    cmd.put     = 1'b1;
                    cmd.put_sel = PUT_PREFIX;
                    state_next  = S_INS;
                end
            end
            S_INS:
            begin
                cmd.insert = 1'b1;
                state_next = S_FULL;
            end
            S_FULL:
            begin
                if (st.need_clear)
                begin
                    state_next = S_CLR;
                end
                else
                begin
                    cmd.set_px = 1'b1;
                    state_next = S_EOI;
                end
            end
            S_CLR:
            begin
                if (st.pk_ready)
                begin
                    cmd.put         = 1'b1;
                    cmd.put_sel     = PUT_CLEAR;
                    cmd.table_reset = 1'b1;
                    cmd.set_px      = 1'b1;
                    state_next      = S_EOI;
                end
            end
            S_EOI:
            begin
                state_next = st.eoi ? S_END1 : S_IDLE;
            end
            S_END1:
            begin
                if (st.pk_ready)
                begin
                    cmd.put     = 1'b1;
                    cmd.put_sel = PUT_PREFIX;
                    state_next  = S_END2;
                end
            end
            S_END2:
            begin
                if (st.pk_ready)
                begin
                    cmd.put     = 1'b1;
                    cmd.put_sel = PUT_END;
                    state_next  = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                cmd.hold_last = 1'b1;
                if (st.flush_ok)
                begin
                    cmd.flush       = 1'b1;
                    cmd.image_reset = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/gle_datapath.sv]
// Dictionary hash memory, code table, width logic, bit packer and output register.
module gle_datapath
    import gle_pkg::*;
#(
    parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  pixel_t in_data,
    output logic   out_valid,
    input  logic   out_stall,
    output byte_t  out_data,
    input  logic   cfg_valid,
    output logic   cfg_ready,
    input  logic [3:0] cfg_data,
    input  cmd_t   cmd,
    output stat_t  st
);

    localparam int DictBits = $clog2(DICT_ENTRIES);
    localparam int HB       = DictBits + 1;
    localparam int Slots    = 1 << HB;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [CODE_BITS-1:0] code;
    } slot_t;

    slot_t               slot_mem [Slots];
    logic [KEY_BITS-1:0] dict_mem [DICT_ENTRIES];

    logic [3:0]           max_bits_reg;
    logic [7:0]           px_reg;
    logic                 eoi_reg;
    logic [CODE_BITS-1:0] prefix_reg;
    logic                 pv_reg;
    logic [12:0]          nfc_reg;
    logic [3:0]           cw_reg;
    logic                 started_reg;
    logic [HB-1:0]        addr_reg;
    slot_t                slot_q_reg;
    logic [KEY_BITS-1:0]  dict_q_reg;
    logic [18:0]          acc_reg;
    logic [4:0]           cnt_reg;
    logic                 ob_valid_reg;
    byte_t                ob_reg;
    logic [HB:0]          init_cnt_reg;

    logic [18:0]          acc_next;
    logic [4:0]           cnt_next;
    logic [12:0]          nfc_ins;
    logic [3:0]           cw_ins;
    logic [3:0]           widest;
    logic [KEY_BITS-1:0]  key;
    logic [HB-1:0]        hash;
    logic [12:0]          hash_mix;
    logic [CODE_BITS-1:0] put_code;
    logic [CODE_BITS-1:0] put_masked;
    logic [12:0]          width_mask;
    logic                 accepted;
    logic                 init_busy;
    logic                 can_load;
    logic                 drain;
    logic                 room;

    // Clamp the widest width to the legal range and to the table size
    function automatic logic [3:0] widest_f(input logic [3:0] m_in);
        logic [3:0] m;
        m = m_in;
        if (m < START_WIDTH)
        begin
            m = START_WIDTH;
        end
        if (m > WIDTH_CAP)
        begin
            m = WIDTH_CAP;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (m > START_WIDTH && (14'd1 << m) > 14'(DICT_ENTRIES))
            begin
                m = m - 4'd1;
            end
        end
        return m;
    endfunction

    assign init_busy = !init_cnt_reg[HB];
    assign in_stall  = !cmd.take_ok;
    assign accepted  = in_valid && cmd.take_ok;
    assign cfg_ready = 1'b1;
    assign out_valid = ob_valid_reg;
    assign out_data  = ob_reg;

    assign key      = {prefix_reg, px_reg};
    assign hash_mix = {1'b0, prefix_reg} ^ {px_reg, 5'd0};
    assign hash     = hash_mix[HB-1:0];
    assign widest   = widest_f(max_bits_reg);
    assign room     = nfc_reg < 13'(DICT_ENTRIES);
    assign nfc_ins  = room ? nfc_reg + 13'd1 : nfc_reg;
    assign cw_ins   = (cw_reg < WIDTH_CAP && (14'd1 << cw_reg) < {1'b0, nfc_ins})
                      ? cw_reg + 4'd1 : cw_reg;

    // Status to the controller
    always_comb
    begin
        st.accepted     = accepted;
        st.init_busy    = init_busy;
        st.started      = started_reg;
        st.prefix_valid = pv_reg;
        st.eoi          = eoi_reg;
        st.pk_ready     = cnt_reg < 5'd8;
        st.flush_ok     = can_load && cnt_reg <= 5'd8;
        st.slot_live    = slot_q_reg.code >= FIRST_FREE
                          && {1'b0, slot_q_reg.code} < nfc_reg;
        st.dict_ok      = dict_q_reg == slot_q_reg.key;
        st.key_eq       = slot_q_reg.key == key;
        st.need_clear   = cw_reg >= widest && (14'd1 << cw_reg) <= {1'b0, nfc_reg};
    end

    // Select and mask the code for the packer
    always_comb
    begin
        unique case (cmd.put_sel)
            PUT_CLEAR:  put_code = CLEAR_CODE;
            PUT_END:    put_code = END_CODE;
            PUT_PREFIX: put_code = prefix_reg;
            default:    put_code = prefix_reg;
        endcase
        width_mask = (13'd1 << cw_reg) - 13'd1;
        put_masked = put_code & width_mask[CODE_BITS-1:0];
    end

    // Pack codes LSB-first and drain whole bytes
    assign can_load = !ob_valid_reg || !out_stall;
    assign drain    = can_load && cnt_reg >= 5'd8 && !(cmd.hold_last && cnt_reg == 5'd8);

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (cmd.put)
        begin
            acc_next = acc_reg | ({7'd0, put_masked} << cnt_reg[2:0]);
            cnt_next = cnt_reg + {1'b0, cw_reg};
        end
        else if (cmd.flush)
        begin
            acc_next = '0;
            cnt_next = '0;
        end
        else if (drain)
        begin
            acc_next = acc_reg >> 8;
            cnt_next = cnt_reg - 5'd8;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bits_reg <= MAX_BITS_RESET;
            prefix_reg   <= '0;
            pv_reg       <= 1'b0;
            nfc_reg      <= {1'b0, FIRST_FREE};
            cw_reg       <= START_WIDTH;
            started_reg  <= 1'b0;
            acc_reg      <= '0;
            cnt_reg      <= '0;
            ob_valid_reg <= 1'b0;
            init_cnt_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            if (cfg_valid)
            begin
                max_bits_reg <= cfg_data;
            end
            if (init_busy)
            begin
                init_cnt_reg <= init_cnt_reg + 1'b1;
            end
            if (drain || cmd.flush)
            begin
                ob_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ob_valid_reg <= 1'b0;
            end
            if (cmd.mark_start)
            begin
                started_reg <= 1'b1;
            end
            if (cmd.set_pv)
            begin
                pv_reg <= 1'b1;
            end
            if (cmd.set_px)
            begin
                prefix_reg <= {4'd0, px_reg};
            end
            else if (cmd.take_code)
            begin
                prefix_reg <= slot_q_reg.code;
            end
            if (cmd.insert)
            begin
                nfc_reg <= nfc_ins;
                cw_reg  <= cw_ins;
            end
            if (cmd.table_reset)
            begin
                nfc_reg <= {1'b0, FIRST_FREE};
                cw_reg  <= START_WIDTH;
            end
            if (cmd.image_reset)
            begin
                nfc_reg     <= {1'b0, FIRST_FREE};
                cw_reg      <= START_WIDTH;
                prefix_reg  <= '0;
                pv_reg      <= 1'b0;
                started_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accepted)
        begin
            px_reg  <= in_data.pixel_index;
            eoi_reg <= in_data.end_of_image;
        end
        if (cmd.probe_start)
        begin
            addr_reg <= hash;
        end
        else if (cmd.probe_next)
        begin
            addr_reg <= addr_reg + 1'b1;
        end
        if (cmd.flush)
        begin
            ob_reg.packed_byte <= acc_reg[7:0];
            ob_reg.final_byte  <= 1'b1;
        end
        else if (drain)
        begin
            ob_reg.packed_byte <= acc_reg[7:0];
            ob_reg.final_byte  <= 1'b0;
        end
    end

    // Hash slot memory: clear once after reset, then insert
    always_ff @(posedge clk)
    begin
        if (init_busy)
        begin
            slot_mem[init_cnt_reg[HB-1:0]] <= '0;
        end
        else if (cmd.insert && room)
        begin
            slot_mem[addr_reg] <= '{key: key, code: nfc_reg[CODE_BITS-1:0]};
        end
        slot_q_reg <= slot_mem[addr_reg];
    end

    // Code table, valid below the next free code
    always_ff @(posedge clk)
    begin
        if (cmd.insert && room)
        begin
            dict_mem[nfc_reg[DictBits-1:0]] <= key;
        end
        dict_q_reg <= dict_mem[slot_q_reg.code[DictBits-1:0]];
    end

endmodule

[rtl/gif_lzw_encoder_unit.sv]
// GIF LZW encoder: takes palette indices and delivers the packed code stream as bytes.
//
// Input channel in_valid/in_stall/in_data carries one pixel and its end-of-image
// flag per beat. Output channel out_valid/out_stall/out_data carries one packed
// byte per beat; final_byte marks the last byte of an image. The cfg channel
// (cfg_valid/cfg_ready/cfg_data) writes the widest code width; it is always ready.
// One pixel is worked on at a time. The first pixel of an image puts a clear code
// and becomes the prefix; a later pixel extends the string on a hash hit or, on
// a miss that stops at a free slot, puts the prefix code and inserts a new entry.
// A probe that passes a slot of another string moves on to the next slot, a dead
// slot that still looks live counts as a miss, and a full table adds a clear code.
// Each hash probe costs two dependent reads: the slot memory and then the code
// table that confirms the slot is live. An end-of-image pixel adds two code puts
// and the flush of the last partial byte. After reset the hash slot memory, all
// 2*DICT_ENTRIES slots (DICT_ENTRIES rounded up to a power of two, 8192 by
// default), is swept clear, one slot per cycle; in_stall is high during the sweep.
// When the receiver stalls, the output register holds its byte; the packer keeps
// at most 19 bits, so the encoder waits before putting another code, and the
// input channel stays stalled until the current pixel is finished.
module gif_lzw_encoder_unit
    import gle_pkg::*;
#(
    parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  pixel_t     in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output byte_t      out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data
);

    cmd_t  cmd;
    stat_t st;

    // Sequencer
    gle_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    // Tables, packer and output stage
    gle_datapath #(
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st)
    );

`ifndef NO_ASSERTIONS
    // Put a code only when the packer has room for it
    assert property (@(posedge clk) disable iff (!rst_n) cmd.put |-> st.pk_ready)
        else $error("code put with packer full");

    // Never put a code and flush in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n) !(cmd.put && cmd.flush))
        else $error("put and flush together");

    // Take one pixel at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second pixel taken while busy");

    // A flushed byte lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> (out_valid && out_data.final_byte))
        else $error("final byte not presented");
`endif

endmodule
